// ===== src/bsp_pkg.sv =====
// ----------------------------------------------------------------------------
// bsp_pkg: shared types and constants for the bounded stack with purge
// Capacity, field widths, command and status codes and controller states.
// ----------------------------------------------------------------------------
`default_nettype none

package bsp_pkg;

	// Stack geometry
	localparam int CAPACITY = 64;
	localparam int DATA_W   = 32;
	localparam int ADDR_W   = $clog2(CAPACITY);
	localparam int CNT_W    = $clog2(CAPACITY + 1);
	localparam int DEPTH_W  = 7;

	// Command codes
	typedef enum logic [2:0] {
		CMD_PUSH  = 3'd0,
		CMD_POP   = 3'd1,
		CMD_PEEK  = 3'd2,
		CMD_CLEAR = 3'd3,
		CMD_PURGE = 3'd4
	} cmd_t;

	// Result status codes
	typedef enum logic [1:0] {
		STS_OK        = 2'd0,
		STS_OVERFLOW  = 2'd1,
		STS_UNDERFLOW = 2'd2
	} status_t;

	// Controller states
	typedef enum logic [1:0] {
		S_IDLE,
		S_READ,
		S_PURGE
	} state_t;

endpackage

`default_nettype wire

// ===== src/bounded_stack_with_purge_top.sv =====
// ----------------------------------------------------------------------------
// bounded_stack_with_purge_top: bounded LIFO stack of signed 32-bit entries
//
// A command is taken at a rising edge where start is high and busy is low.
// Each command yields exactly one transaction on the result ports, marked by
// a one-cycle done strobe; the receiver cannot stall, so results are never
// held back.
// Sequence of each command, from the accepting edge to the done strobe:
//   push, clear, unknown codes, and any pop, peek or purge on an empty stack:
//     done in the next cycle, busy stays low, one command per cycle.
//   pop or peek on a held entry: the entry is fetched from the stack RAM,
//     whose read data is registered; busy is high for one cycle, done follows.
//   purge: the held entries are walked through the single read port, one
//     per cycle, and survivors are compacted through the write port;
//     busy is high while the walk runs, done follows.
// depth_now, is_empty and is_full show the count after the command.
// Reset empties the stack at once; the RAM itself is never cleared.
// ----------------------------------------------------------------------------
`default_nettype none

module bounded_stack_with_purge_top
	import bsp_pkg::*;
(
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     start,
	input  wire logic [2:0]               command,
	input  wire logic signed [DATA_W-1:0] value,
	output logic                          busy,
	output logic                          done,
	output logic [1:0]                    status,
	output logic signed [DATA_W-1:0]      top_value,
	output logic [DEPTH_W-1:0]            depth_now,
	output logic                          is_empty,
	output logic                          is_full
);

	state_t             state_q, state_d;
	logic [CNT_W-1:0]   count_q;
	logic               done_q, done_d;
	status_t            status_q;
	logic [DATA_W-1:0]  top_q;
	logic [DATA_W-1:0]  victim_q;
	logic [CNT_W-1:0]   kept_q, kept_next;
	logic [ADDR_W-1:0]  chk_idx_q;
	logic [CNT_W-1:0]   rd_idx_q;

	logic               accept, empty, full, keep, last;
	logic               ram_we;
	logic [ADDR_W-1:0]  ram_waddr, ram_raddr;
	logic [DATA_W-1:0]  ram_wdata, ram_rdata;

	// Stack storage
	bsp_ram #(
		.WIDTH (DATA_W),
		.DEPTH (CAPACITY)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// Decode the current transaction and purge progress
	assign accept    = start && (state_q == S_IDLE);
	assign empty     = (count_q == '0);
	assign full      = (count_q == CNT_W'(CAPACITY));
	assign keep      = (ram_rdata != victim_q);
	assign kept_next = kept_q + CNT_W'(keep);
	assign last      = (state_q == S_PURGE) && (CNT_W'(chk_idx_q) == count_q - CNT_W'(1));

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (accept && !empty) begin
					if (command == CMD_POP || command == CMD_PEEK) begin
						state_d = S_READ;
					end else if (command == CMD_PURGE) begin
						state_d = S_PURGE;
					end
				end
			end
			S_READ: begin
				state_d = S_IDLE;
			end
			S_PURGE: begin
				if (last) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// RAM ports, busy and done strobe.
	// Purge writes land at kept <= checked index, below every address still
	// to be read, so the walk needs no forwarding.
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = count_q[ADDR_W-1:0];
		ram_wdata = value;
		ram_raddr = count_q[ADDR_W-1:0] - ADDR_W'(1);
		busy      = 1'b0;
		done_d    = 1'b0;
		case (state_q)
			S_IDLE: begin
				if (accept && command == CMD_PUSH && !full) begin
					ram_we = 1'b1;
				end
				if (command == CMD_PURGE) begin
					ram_raddr = '0;
				end
				done_d = accept && (state_d == S_IDLE);
			end
			S_READ: begin
				busy   = 1'b1;
				done_d = 1'b1;
			end
			S_PURGE: begin
				busy      = 1'b1;
				ram_we    = keep;
				ram_waddr = kept_q[ADDR_W-1:0];
				ram_wdata = ram_rdata;
				ram_raddr = rd_idx_q[ADDR_W-1:0];
				done_d    = last;
			end
			default: begin
				busy = 1'b1;
			end
		endcase
	end

	// Control state: state, count and strobe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			count_q <= '0;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= done_d;
			if (accept) begin
				case (command)
					CMD_PUSH: begin
						if (!full) begin
							count_q <= count_q + CNT_W'(1);
						end
					end
					CMD_POP: begin
						if (!empty) begin
							count_q <= count_q - CNT_W'(1);
						end
					end
					CMD_CLEAR: begin
						count_q <= '0;
					end
					default: begin
						count_q <= count_q;
					end
				endcase
			end else if (last) begin
				count_q <= kept_next;
			end
		end
	end

	// Result payload and purge walk registers
	always_ff @(posedge clk) begin
		if (accept) begin
			top_q     <= '0;
			status_q  <= STS_OK;
			victim_q  <= value;
			kept_q    <= '0;
			chk_idx_q <= '0;
			rd_idx_q  <= CNT_W'(1);
			if (command == CMD_PUSH && full) begin
				status_q <= STS_OVERFLOW;
			end else if ((command == CMD_POP || command == CMD_PEEK) && empty) begin
				status_q <= STS_UNDERFLOW;
			end
		end else if (state_q == S_READ) begin
			top_q <= ram_rdata;
		end else if (state_q == S_PURGE) begin
			kept_q    <= kept_next;
			chk_idx_q <= chk_idx_q + ADDR_W'(1);
			rd_idx_q  <= rd_idx_q + CNT_W'(1);
		end
	end

	// Drive the result ports
	assign done      = done_q;
	assign status    = status_q;
	assign top_value = top_q;
	assign depth_now = DEPTH_W'(count_q);
	assign is_empty  = empty;
	assign is_full   = full;

endmodule

`default_nettype wire

// ===== src/bsp_ram.sv =====
// ----------------------------------------------------------------------------
// bsp_ram: generic single-clock RAM
// One write port and one read port; read data registered.
// ----------------------------------------------------------------------------
`default_nettype none

module bsp_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write, then register the read word
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

`default_nettype wire

// ===== src/bsp_checker.sv =====
// ----------------------------------------------------------------------------
// bsp_checker: port-level checks for the bounded stack with purge
// Watches the command and result ports and flags broken stack behaviour.
// ----------------------------------------------------------------------------
`default_nettype none

module bsp_checker
	import bsp_pkg::*;
(
	input wire logic                     clk,
	input wire logic                     arst_n,
	input wire logic                     start,
	input wire logic [2:0]               command,
	input wire logic                     busy,
	input wire logic                     done,
	input wire logic [1:0]               status,
	input wire logic signed [DATA_W-1:0] top_value,
	input wire logic [DEPTH_W-1:0]       depth_now,
	input wire logic                     is_empty,
	input wire logic                     is_full
);

	// A result never coincides with a busy cycle
	a_done_not_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result strobe while busy");

	// Clear answers next cycle with an empty stack
	a_clear: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && command == CMD_CLEAR |=> done && is_empty && depth_now == '0)
		else $error("clear did not empty the stack");

	// A push that fits grows the count by one in the next result
	a_push: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && command == CMD_PUSH && !is_full
		|=> done && status == STS_OK && depth_now == DEPTH_W'($past(depth_now) + 1'b1))
		else $error("push did not grow the stack");

	// Overflow only from a full stack, with no entry returned
	a_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		done && status == STS_OVERFLOW |-> is_full && top_value == '0)
		else $error("overflow reported on a stack that is not full");

	// Underflow only from an empty stack
	a_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		done && status == STS_UNDERFLOW |-> is_empty && top_value == '0)
		else $error("underflow reported on a stack that is not empty");

endmodule

bind bounded_stack_with_purge_top bsp_checker u_bsp_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.start     (start),
	.command   (command),
	.busy      (busy),
	.done      (done),
	.status    (status),
	.top_value (top_value),
	.depth_now (depth_now),
	.is_empty  (is_empty),
	.is_full   (is_full)
);

`default_nettype wire
